FILE: hw/rtl/lftt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lftt_pkg
// Shared constants, types and the quarter-wave sine entry function for the
// leg force to joint torque pipeline.
// ----------------------------------------------------------------------------
package lftt_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SIN_W            = 17;
    localparam int LEN_W            = 16;
    localparam int ADDR_W           = 3;
    localparam int DATA_W           = 32;

    localparam logic [63:0] PIH_Q30 = 64'd1686629713;

    localparam logic [LEN_W-1:0] THIGH_RESET = 16'd22938;
    localparam logic [LEN_W-1:0] SHANK_RESET = 16'd21627;

    typedef enum logic {
        REG_THIGH_LENGTH = 1'b0,
        REG_SHANK_LENGTH = 1'b1
    } lftt_reg_t;

    typedef struct packed {
        logic [LEN_W-1:0] thigh;
        logic [LEN_W-1:0] shank;
    } lftt_cfg_t;

    // Q15 sine of the Q30 angle x, from an eight term Taylor series.
    function automatic logic [15:0] sine_entry(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32768)
        begin
            sum = 64'sd32768;
        end
        return sum[15:0];
    endfunction

endpackage

FILE: hw/rtl/leg_force_to_joint_torque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_force_to_joint_torque
// Maps joint angles and an end-effector force to joint torques, tau = J^T F.
//
// An item is one beat on the input channel (item_valid, item_stall) carrying
// three binary joint angles and a force vector. Each beat yields one result
// beat on the output channel (result_valid, result_stall) with three
// saturated torques and a clip flag. The link lengths are set through the
// register port and should only be changed while the pipeline is empty.
// The datapath is a ten stage pipeline: angle sums, table index, table read,
// link products, A and B sums, trig products, rounding, force products,
// torque sums, then rounding and saturation into the output register.
// An accepted beat is registered in each stage in turn before result_valid
// rises; one beat may be accepted every cycle while item_stall is low.
// When the receiver stalls, each stage holds only while the stage after it
// is full, so empty slots close up; item_stall rises only when all ten
// stages are full and the receiver stalls. Reset empties the pipeline and
// loads the default link lengths.
// ----------------------------------------------------------------------------
module leg_force_to_joint_torque #(
    parameter int ANGLE_BITS       = lftt_pkg::ANGLE_BITS,
    parameter int SINE_TABLE_DEPTH = lftt_pkg::SINE_TABLE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lftt_pkg::ADDR_W-1:0] paddr,
    input  logic [lftt_pkg::DATA_W-1:0] pwdata,
    output logic [lftt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic signed [15:0]          abduction_angle,
    input  logic signed [15:0]          hip_angle,
    input  logic signed [15:0]          knee_angle,
    input  logic signed [23:0]          force_x,
    input  logic signed [23:0]          force_y,
    input  logic signed [23:0]          force_z,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic signed [31:0]          abduction_torque,
    output logic signed [31:0]          hip_torque,
    output logic signed [31:0]          knee_torque,
    output logic                        clipped
);

    localparam int NS    = 10;
    localparam int SIN_W = lftt_pkg::SIN_W;
    localparam logic [ANGLE_BITS-1:0] QTR = {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic signed [51:0] RND15 = 52'sd16384;
    localparam logic signed [63:0] RND31 = 64'sd1073741824;
    localparam logic signed [63:0] T_MAX = 64'sd2147483647;
    localparam logic signed [63:0] T_MIN = -64'sd2147483648;

    lftt_pkg::lftt_cfg_t cfg;

    logic [NS:1] v_reg;
    logic [NS:1] rdy;

    logic signed [31:0] a_ext, h_ext, k_ext;
    logic [ANGLE_BITS-1:0] a_ang, h_ang, k_ang;

    logic [ANGLE_BITS-1:0] sa_ang_reg, ca_ang_reg, s1_ang_reg;
    logic [ANGLE_BITS-1:0] c1_ang_reg, s12_ang_reg, c12_ang_reg;
    logic signed [23:0] fx_reg [1:7];
    logic signed [23:0] fy_reg [1:7];
    logic signed [23:0] fz_reg [1:7];

    logic signed [SIN_W-1:0] sa_val, ca_val, s1_val, c1_val, s12_val, c12_val;
    logic signed [SIN_W-1:0] l2_s, l3_s;

    logic signed [33:0] l2s1_reg, l3s12_reg, l2c1_reg, l3c12_reg;
    logic signed [SIN_W-1:0] sa4_reg, ca4_reg, sa5_reg, ca5_reg;
    logic signed [33:0] asum_reg, bsum_reg, ls12_5_reg, lc12_5_reg;
    logic signed [50:0] p10_reg, p20_reg, p11_reg, p21_reg, p12_reg, p22_reg;
    logic signed [33:0] a6_reg, ls12_6_reg, a7_reg, ls12_7_reg;
    logic signed [51:0] r10, r20, r11, r21, r12, r22;
    logic signed [36:0] j10_reg, j20_reg, j11_reg, j21_reg, j12_reg, j22_reg;
    logic signed [60:0] m10_reg, m20_reg, m11_reg, m21_reg, m12_reg, m22_reg;
    logic signed [60:0] max_reg, mlx_reg;
    logic signed [62:0] s_abd_reg, s_hip_reg, s_knee_reg;
    logic signed [63:0] q_abd, q_hip, q_knee;
    logic signed [31:0] abd_reg, hip_reg, knee_reg;
    logic               clip_reg;

    lftt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: a stage may load when it is empty or the next one moves.
    always_comb
    begin
        rdy[NS] = !v_reg[NS] || !result_stall;
        for (int i = NS - 1; i >= 1; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign item_stall   = !rdy[1];
    assign result_valid = v_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                v_reg[1] <= item_valid;
            end
            for (int i = 2; i <= NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 1: joint angle sums.
    assign a_ext = 32'(abduction_angle);
    assign h_ext = 32'(hip_angle);
    assign k_ext = 32'(knee_angle);
    assign a_ang = a_ext[ANGLE_BITS-1:0];
    assign h_ang = h_ext[ANGLE_BITS-1:0];
    assign k_ang = k_ext[ANGLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            sa_ang_reg  <= a_ang;
            ca_ang_reg  <= a_ang + QTR;
            s1_ang_reg  <= h_ang + QTR;
            c1_ang_reg  <= h_ang + QTR + QTR;
            s12_ang_reg <= h_ang + QTR + k_ang;
            c12_ang_reg <= h_ang + QTR + QTR + k_ang;
            fx_reg[1]   <= force_x;
            fy_reg[1]   <= force_y;
            fz_reg[1]   <= force_z;
        end
        for (int i = 2; i <= 7; i++)
        begin
            if (rdy[i])
            begin
                fx_reg[i] <= fx_reg[i-1];
                fy_reg[i] <= fy_reg[i-1];
                fz_reg[i] <= fz_reg[i-1];
            end
        end
    end

    // Stages 2 and 3: table index and table read.
    lftt_sine_lookup #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sa (
        .clk(clk), .idx_en(rdy[2]), .rd_en(rdy[3]), .angle(sa_ang_reg), .value(sa_val)
    );
    lftt_sine_lookup #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_ca (
        .clk(clk), .idx_en(rdy[2]), .rd_en(rdy[3]), .angle(ca_ang_reg), .value(ca_val)
    );
    lftt_sine_lookup #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_s1 (
        .clk(clk), .idx_en(rdy[2]), .rd_en(rdy[3]), .angle(s1_ang_reg), .value(s1_val)
    );
    lftt_sine_lookup #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_c1 (
        .clk(clk), .idx_en(rdy[2]), .rd_en(rdy[3]), .angle(c1_ang_reg), .value(c1_val)
    );
    lftt_sine_lookup #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_s12 (
        .clk(clk), .idx_en(rdy[2]), .rd_en(rdy[3]), .angle(s12_ang_reg), .value(s12_val)
    );
    lftt_sine_lookup #(.ANGLE_BITS(ANGLE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_c12 (
        .clk(clk), .idx_en(rdy[2]), .rd_en(rdy[3]), .angle(c12_ang_reg), .value(c12_val)
    );

    assign l2_s = signed'({1'b0, cfg.thigh});
    assign l3_s = signed'({1'b0, cfg.shank});

    // Stages 4 to 10: arithmetic.
    assign r10 = 52'(p10_reg) + RND15;
    assign r20 = -52'(p20_reg) + RND15;
    assign r11 = 52'(p11_reg) + RND15;
    assign r21 = 52'(p21_reg) + RND15;
    assign r12 = 52'(p12_reg) + RND15;
    assign r22 = 52'(p22_reg) + RND15;

    assign q_abd  = (64'(s_abd_reg) + RND31) >>> 31;
    assign q_hip  = (64'(s_hip_reg) + RND31) >>> 31;
    assign q_knee = (64'(s_knee_reg) + RND31) >>> 31;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] q);
        if (q > T_MAX)
        begin
            return 32'sh7fffffff;
        end
        else if (q < T_MIN)
        begin
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            l2s1_reg  <= l2_s * s1_val;
            l3s12_reg <= l3_s * s12_val;
            l2c1_reg  <= l2_s * c1_val;
            l3c12_reg <= l3_s * c12_val;
            sa4_reg   <= sa_val;
            ca4_reg   <= ca_val;
        end
        if (rdy[5])
        begin
            asum_reg   <= l2s1_reg + l3s12_reg;
            bsum_reg   <= l2c1_reg + l3c12_reg;
            ls12_5_reg <= l3s12_reg;
            lc12_5_reg <= l3c12_reg;
            sa5_reg    <= sa4_reg;
            ca5_reg    <= ca4_reg;
        end
        if (rdy[6])
        begin
            p10_reg    <= ca5_reg * asum_reg;
            p20_reg    <= sa5_reg * asum_reg;
            p11_reg    <= sa5_reg * bsum_reg;
            p21_reg    <= ca5_reg * bsum_reg;
            p12_reg    <= sa5_reg * lc12_5_reg;
            p22_reg    <= ca5_reg * lc12_5_reg;
            a6_reg     <= asum_reg;
            ls12_6_reg <= ls12_5_reg;
        end
        if (rdy[7])
        begin
            j10_reg    <= r10[51:15];
            j20_reg    <= r20[51:15];
            j11_reg    <= r11[51:15];
            j21_reg    <= r21[51:15];
            j12_reg    <= r12[51:15];
            j22_reg    <= r22[51:15];
            a7_reg     <= a6_reg;
            ls12_7_reg <= ls12_6_reg;
        end
        if (rdy[8])
        begin
            m10_reg <= j10_reg * fy_reg[7];
            m20_reg <= j20_reg * fz_reg[7];
            m11_reg <= j11_reg * fy_reg[7];
            m21_reg <= j21_reg * fz_reg[7];
            m12_reg <= j12_reg * fy_reg[7];
            m22_reg <= j22_reg * fz_reg[7];
            max_reg <= a7_reg * fx_reg[7];
            mlx_reg <= ls12_7_reg * fx_reg[7];
        end
        if (rdy[9])
        begin
            s_abd_reg  <= 63'(m10_reg) + 63'(m20_reg);
            s_hip_reg  <= 63'(m11_reg) + 63'(m21_reg) - 63'(max_reg);
            s_knee_reg <= 63'(m12_reg) + 63'(m22_reg) - 63'(mlx_reg);
        end
        if (rdy[10])
        begin
            abd_reg  <= sat32(q_abd);
            hip_reg  <= sat32(q_hip);
            knee_reg <= sat32(q_knee);
            clip_reg <= (q_abd > T_MAX) || (q_abd < T_MIN) ||
                        (q_hip > T_MAX) || (q_hip < T_MIN) ||
                        (q_knee > T_MAX) || (q_knee < T_MIN);
        end
    end

    assign abduction_torque = abd_reg;
    assign hip_torque       = hip_reg;
    assign knee_torque      = knee_reg;
    assign clipped          = clip_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (&v_reg))
        else $error("Input stalled while the pipeline has an empty stage.");

    a_out_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
        rdy[NS] |=> (v_reg[NS] == $past(v_reg[NS-1])))
        else $error("Output beat does not follow the last arithmetic stage.");

    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && clipped) |->
        ((abd_reg == 32'sh7fffffff) || (abd_reg == 32'sh80000000) ||
         (hip_reg == 32'sh7fffffff) || (hip_reg == 32'sh80000000) ||
         (knee_reg == 32'sh7fffffff) || (knee_reg == 32'sh80000000)))
        else $error("Clip flag set without a saturated torque.");
`endif

endmodule

FILE: hw/rtl/lftt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lftt_cfg_regs
// Register port holding the two link lengths.
// ----------------------------------------------------------------------------
module lftt_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lftt_pkg::ADDR_W-1:0] paddr,
    input  logic [lftt_pkg::DATA_W-1:0] pwdata,
    output logic [lftt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output lftt_pkg::lftt_cfg_t         cfg
);

    logic [lftt_pkg::LEN_W-1:0] thigh_reg;
    logic [lftt_pkg::LEN_W-1:0] shank_reg;
    logic                       wr_en;
    lftt_pkg::lftt_reg_t        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = lftt_pkg::lftt_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thigh_reg <= lftt_pkg::THIGH_RESET;
            shank_reg <= lftt_pkg::SHANK_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                lftt_pkg::REG_THIGH_LENGTH: thigh_reg <= pwdata[lftt_pkg::LEN_W-1:0];
                lftt_pkg::REG_SHANK_LENGTH: shank_reg <= pwdata[lftt_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            lftt_pkg::REG_THIGH_LENGTH: prdata = 32'(thigh_reg);
            lftt_pkg::REG_SHANK_LENGTH: prdata = 32'(shank_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.thigh = thigh_reg;
    assign cfg.shank = shank_reg;

endmodule

FILE: hw/rtl/lftt_sine_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lftt_sine_lookup
// Two stage sine lookup: quadrant folding and table index, then a registered
// read of the quarter-wave table with the quadrant sign applied.
// ----------------------------------------------------------------------------
module lftt_sine_lookup #(
    parameter int ANGLE_BITS       = lftt_pkg::ANGLE_BITS,
    parameter int SINE_TABLE_DEPTH = lftt_pkg::SINE_TABLE_DEPTH
) (
    input  logic                              clk,
    input  logic                              idx_en,
    input  logic                              rd_en,
    input  logic [ANGLE_BITS-1:0]             angle,
    output logic signed [lftt_pkg::SIN_W-1:0] value
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int POS_W  = ANGLE_BITS - 1;
    localparam int PROD_W = POS_W + IDX_W;
    localparam logic [POS_W-1:0] QTR     = {1'b1, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [IDX_W:0]   DEPTH_I = (IDX_W+1)'(SINE_TABLE_DEPTH);

    logic [15:0]       tbl [0:SINE_TABLE_DEPTH];
    logic [1:0]        quad;
    logic [POS_W-1:0]  pos;
    logic [PROD_W-1:0] prod;
    logic [IDX_W:0]    scaled;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  idx_reg;
    logic              neg_idx_reg;
    logic [15:0]       mag_reg;
    logic              neg_reg;
    logic signed [lftt_pkg::SIN_W-1:0] mag_s;

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++)
    begin : g_tbl
        localparam logic [63:0] X =
            (lftt_pkg::PIH_Q30 * 64'(gi)) / 64'(SINE_TABLE_DEPTH);
        assign tbl[gi] = lftt_pkg::sine_entry(X);
    end

    always_comb
    begin
        quad = angle[ANGLE_BITS-1:ANGLE_BITS-2];
        pos  = {1'b0, angle[ANGLE_BITS-3:0]};
        if (quad[0])
        begin
            pos = QTR - pos;
        end
        prod   = PROD_W'(pos) * PROD_W'(SINE_TABLE_DEPTH);
        scaled = prod[PROD_W-1:ANGLE_BITS-2];
        if (scaled > DEPTH_I)
        begin
            idx_next = DEPTH_I[IDX_W-1:0];
        end
        else
        begin
            idx_next = scaled[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (idx_en)
        begin
            idx_reg     <= idx_next;
            neg_idx_reg <= quad[1];
        end
        if (rd_en)
        begin
            mag_reg <= tbl[idx_reg];
            neg_reg <= neg_idx_reg;
        end
    end

    assign mag_s = signed'({1'b0, mag_reg});
    assign value = neg_reg ? -mag_s : mag_s;

endmodule
